[design/wcar_pkg.sv]
// Shared constants, types and helpers for the weighted choice block.
package wcar_pkg;

   // Table geometry
   localparam int MAX_ENTRIES = 32;
   localparam int IDX_W       = $clog2(MAX_ENTRIES);
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int WEIGHT_W    = 14;
   localparam int WEIGHT_MAX  = 10000;
   localparam int TOTAL_W     = $clog2(MAX_ENTRIES * WEIGHT_MAX + 1);
   localparam int RAND_W      = 32;
   localparam int BIT_W       = $clog2(RAND_W);
   localparam int RAW_W       = 16;
   localparam int AVOID_W     = 6;
   localparam int CSR_W       = 6;

   // Commands on the request channel
   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_CHOOSE = 1'b1;

   // Result status codes
   localparam logic [1:0] ST_WRITTEN = 2'd0;
   localparam logic [1:0] ST_CHOSEN  = 2'd1;
   localparam logic [1:0] ST_EMPTY   = 2'd2;

   // Kinds of result the controller asks the datapath to emit
   localparam logic [2:0] EMIT_WRITE    = 3'd0;
   localparam logic [2:0] EMIT_EMPTY    = 3'd1;
   localparam logic [2:0] EMIT_SINGLE   = 3'd2;
   localparam logic [2:0] EMIT_HIT      = 3'd3;
   localparam logic [2:0] EMIT_FALLBACK = 3'd4;

   typedef struct packed {
      logic       store;
      logic       load;
      logic       sum_step;
      logic       div_init;
      logic       div_step;
      logic       walk_init;
      logic       walk_step;
      logic       emit;
      logic [2:0] emit_kind;
   } ctrl_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic count_one;
      logic sum_done;
      logic total_zero;
      logic div_last;
      logic walk_hit;
      logic walk_end;
   } dp_status_type;

   // Clamp a signed raw weight to 1..WEIGHT_MAX
   function automatic logic [WEIGHT_W-1:0] clamp_weight(input logic signed [RAW_W-1:0] raw);
      logic [WEIGHT_W-1:0] res;
      if (raw < 16'sd1) begin
         res = WEIGHT_W'(1);
      end else if (raw > 16'(WEIGHT_MAX)) begin
         res = WEIGHT_W'(WEIGHT_MAX);
      end else begin
         res = raw[WEIGHT_W-1:0];
      end
      return res;
   endfunction

endpackage

[design/wcar_ram.sv]
// Generic single-port-write, registered-read RAM.
module wcar_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/wcar_ctrl.sv]
// Controller state machine sequencing sum, modulo and walk phases.
module wcar_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   req_command,
   input  wcar_pkg::dp_status_type stat,
   output wcar_pkg::ctrl_cmd_type  cmd,
   output logic                   busy
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SUM  = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;
   localparam logic [1:0] S_WALK = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // Next state and command decode
   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.emit_kind = wcar_pkg::EMIT_WRITE;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_command == wcar_pkg::CMD_WRITE) begin
                  cmd.store     = 1'b1;
                  cmd.emit      = 1'b1;
                  cmd.emit_kind = wcar_pkg::EMIT_WRITE;
               end else if (stat.count_zero) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_kind = wcar_pkg::EMIT_EMPTY;
               end else if (stat.count_one) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_kind = wcar_pkg::EMIT_SINGLE;
               end else begin
                  cmd.load = 1'b1;
                  state_in = S_SUM;
               end
            end
         end
         S_SUM: begin
            cmd.sum_step = 1'b1;
            if (stat.sum_done) begin
               if (stat.total_zero) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_kind = wcar_pkg::EMIT_FALLBACK;
                  state_in      = S_IDLE;
               end else begin
                  cmd.div_init = 1'b1;
                  state_in     = S_DIV;
               end
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               cmd.walk_init = 1'b1;
               state_in      = S_WALK;
            end
         end
         S_WALK: begin
            cmd.walk_step = 1'b1;
            if (stat.walk_hit) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = wcar_pkg::EMIT_HIT;
               state_in      = S_IDLE;
            end else if (stat.walk_end) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = wcar_pkg::EMIT_FALLBACK;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[design/wcar_dp.sv]
// Datapath: weight table, running total, bit-serial modulo and cumulative walk.
module wcar_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  wcar_pkg::ctrl_cmd_type                 cmd,
   output wcar_pkg::dp_status_type                stat,
   input  logic                                  csr_we,
   input  logic [wcar_pkg::CSR_W-1:0]            csr_wdata,
   input  logic [wcar_pkg::IDX_W-1:0]            req_entry_index,
   input  logic signed [wcar_pkg::RAW_W-1:0]     req_raw_weight,
   input  logic signed [wcar_pkg::AVOID_W-1:0]   req_avoid_index,
   input  logic [wcar_pkg::RAND_W-1:0]           req_random_word,
   output logic                                  rsp_valid,
   output logic [1:0]                            rsp_status,
   output logic [wcar_pkg::IDX_W-1:0]            rsp_chosen_index
);

   logic [wcar_pkg::CSR_W-1:0]    entry_count_ff;
   logic [wcar_pkg::CNT_W-1:0]    n_ff, n_in;
   logic [wcar_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic [wcar_pkg::IDX_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                          rd_vld_ff, rd_vld_in;
   logic [wcar_pkg::TOTAL_W-1:0]  total_ff, total_in;
   logic [wcar_pkg::TOTAL_W-1:0]  rem_ff, rem_in;
   logic [wcar_pkg::RAND_W-1:0]   rnd_ff, rnd_in;
   logic [wcar_pkg::BIT_W-1:0]    bit_ff, bit_in;
   logic [wcar_pkg::AVOID_W-1:0]  avoid_ff, avoid_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [1:0]                    status_ff, status_in;
   logic [wcar_pkg::IDX_W-1:0]    index_ff, index_in;

   logic [wcar_pkg::WEIGHT_W-1:0] rd_data;
   logic                          issue;
   logic                          avoided;
   logic [wcar_pkg::TOTAL_W:0]    trial;
   logic [wcar_pkg::TOTAL_W:0]    trial_diff;
   logic [wcar_pkg::TOTAL_W-1:0]  rd_wide;
   logic                          below;
   logic [wcar_pkg::IDX_W-1:0]    fallback_idx;

   // Weight table
   wcar_ram #(
      .WIDTH (wcar_pkg::WEIGHT_W),
      .DEPTH (wcar_pkg::MAX_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.store),
      .wr_addr (req_entry_index),
      .wr_data (wcar_pkg::clamp_weight(req_raw_weight)),
      .rd_addr (cnt_ff[wcar_pkg::IDX_W-1:0]),
      .rd_data (rd_data)
   );

   // Status towards the controller
   assign issue   = (cmd.sum_step || cmd.walk_step) && (cnt_ff < n_ff);
   assign avoided = !avoid_ff[wcar_pkg::AVOID_W-1] &&
                    (avoid_ff[wcar_pkg::IDX_W-1:0] == rd_idx_ff);
   assign rd_wide = wcar_pkg::TOTAL_W'(rd_data);
   assign below   = (rem_ff < rd_wide);
   assign trial      = {rem_ff, rnd_ff[wcar_pkg::RAND_W-1]};
   assign trial_diff = trial - {1'b0, total_ff};
   assign fallback_idx = (avoid_ff == '0) ? wcar_pkg::IDX_W'(1) : '0;

   always_comb begin
      stat.count_zero = (entry_count_ff == '0);
      stat.count_one  = (entry_count_ff == wcar_pkg::CSR_W'(1));
      stat.sum_done   = (cnt_ff == n_ff) && !rd_vld_ff;
      stat.total_zero = (total_ff == '0);
      stat.div_last   = (bit_ff == wcar_pkg::BIT_W'(wcar_pkg::RAND_W - 1));
      stat.walk_hit   = rd_vld_ff && !avoided && below;
      stat.walk_end   = (cnt_ff == n_ff) && !rd_vld_ff;
   end

   // Phase registers: table sweep, total, modulo and walk remainder
   always_comb begin
      n_in      = n_ff;
      cnt_in    = cnt_ff;
      rd_idx_in = cnt_ff[wcar_pkg::IDX_W-1:0];
      rd_vld_in = issue;
      total_in  = total_ff;
      rem_in    = rem_ff;
      rnd_in    = rnd_ff;
      bit_in    = bit_ff;
      avoid_in  = avoid_ff;

      if (issue) begin
         cnt_in = cnt_ff + wcar_pkg::CNT_W'(1);
      end

      // capture the transaction and clamp the active count
      if (cmd.load) begin
         if (entry_count_ff > wcar_pkg::CSR_W'(wcar_pkg::MAX_ENTRIES)) begin
            n_in = wcar_pkg::CNT_W'(wcar_pkg::MAX_ENTRIES);
         end else begin
            n_in = wcar_pkg::CNT_W'(entry_count_ff);
         end
         cnt_in    = '0;
         rd_vld_in = 1'b0;
         total_in  = '0;
         rnd_in    = req_random_word;
         avoid_in  = req_avoid_index;
      end

      // accumulate non-avoided weights
      if (cmd.sum_step && rd_vld_ff && !avoided) begin
         total_in = total_ff + rd_wide;
      end

      if (cmd.div_init) begin
         rem_in = '0;
         bit_in = '0;
      end

      // one restoring division step per cycle, keep only the remainder
      if (cmd.div_step) begin
         if (trial >= {1'b0, total_ff}) begin
            rem_in = trial_diff[wcar_pkg::TOTAL_W-1:0];
         end else begin
            rem_in = trial[wcar_pkg::TOTAL_W-1:0];
         end
         rnd_in = {rnd_ff[wcar_pkg::RAND_W-2:0], 1'b0};
         bit_in = bit_ff + wcar_pkg::BIT_W'(1);
      end

      // restart the sweep for the walk
      if (cmd.walk_init) begin
         cnt_in    = '0;
         rd_vld_in = 1'b0;
      end

      // step down the cumulative spans
      if (cmd.walk_step && rd_vld_ff && !avoided && !below) begin
         rem_in = rem_ff - rd_wide;
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = cmd.emit;
      status_in    = status_ff;
      index_in     = index_ff;
      if (cmd.emit) begin
         case (cmd.emit_kind)
            wcar_pkg::EMIT_WRITE: begin
               status_in = wcar_pkg::ST_WRITTEN;
               index_in  = '0;
            end
            wcar_pkg::EMIT_EMPTY: begin
               status_in = wcar_pkg::ST_EMPTY;
               index_in  = '0;
            end
            wcar_pkg::EMIT_SINGLE: begin
               status_in = wcar_pkg::ST_CHOSEN;
               index_in  = '0;
            end
            wcar_pkg::EMIT_HIT: begin
               status_in = wcar_pkg::ST_CHOSEN;
               index_in  = rd_idx_ff;
            end
            default: begin
               status_in = wcar_pkg::ST_CHOSEN;
               index_in  = fallback_idx;
            end
         endcase
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
         cnt_ff         <= '0;
         rd_vld_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         n_ff           <= '0;
         bit_ff         <= '0;
      end else begin
         if (csr_we) begin
            entry_count_ff <= csr_wdata;
         end
         cnt_ff       <= cnt_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         n_ff         <= n_in;
         bit_ff       <= bit_in;
      end
   end

   // Payload state
   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      total_ff  <= total_in;
      rem_ff    <= rem_in;
      rnd_ff    <= rnd_in;
      avoid_ff  <= avoid_in;
      status_ff <= status_in;
      index_ff  <= index_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_chosen_index = index_ff;

endmodule

[design/weighted_choice_avoid_repeat.sv]
// Weighted roulette-wheel choice with an avoided entry: top level.
// A write, an empty or single-entry choice answers in the cycle after start.
// A full choice sums the table, runs a bit-serial modulo of the random word and then
// walks the cumulative spans; the table's single read port sets the sweeps.
// A new transaction is taken once busy falls; results are strobes, no stall.
// Synchronous reset clears the entry count and control; table contents are kept.
module weighted_choice_avoid_repeat (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_command,
   input  logic [wcar_pkg::IDX_W-1:0]          req_entry_index,
   input  logic signed [wcar_pkg::RAW_W-1:0]   req_raw_weight,
   input  logic signed [wcar_pkg::AVOID_W-1:0] req_avoid_index,
   input  logic [wcar_pkg::RAND_W-1:0]         req_random_word,
   output logic                                rsp_valid,
   output logic [1:0]                          rsp_status,
   output logic [wcar_pkg::IDX_W-1:0]          rsp_chosen_index,
   input  logic                                csr_we,
   input  logic [wcar_pkg::CSR_W-1:0]          csr_wdata
);

   wcar_pkg::ctrl_cmd_type  cmd;
   wcar_pkg::dp_status_type stat;

   // Sequencer
   wcar_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_command),
      .stat        (stat),
      .cmd         (cmd),
      .busy        (busy)
   );

   // Table and arithmetic
   wcar_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .req_entry_index  (req_entry_index),
      .req_raw_weight   (req_raw_weight),
      .req_avoid_index  (req_avoid_index),
      .req_random_word  (req_random_word),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_chosen_index (rsp_chosen_index)
   );

endmodule
